// ===== rtl/pbv_pkg.sv =====
// Package for the plane tangent basis block: types, widths and defaults.
package pbv_pkg;

    localparam int VECTOR_FRAC_BITS_DEF = 14;

    localparam int VEC_W    = 16;  // normal, up, right
    localparam int DIST_W   = 32;  // offset, origin (Q24.8)
    localparam int WIDE_W   = 33;  // unnormalized vector components
    localparam int MAG_W    = 32;  // magnitude of an unnormalized component
    localparam int SUM_W    = 64;  // sum of squares
    localparam int ROOT_STG = 32;  // one root bit per stage
    localparam int QUO_BITS = 17;  // quotient bits before saturation

    typedef struct packed {
        logic signed [VEC_W-1:0]  normal_x;
        logic signed [VEC_W-1:0]  normal_y;
        logic signed [VEC_W-1:0]  normal_z;
        logic signed [DIST_W-1:0] plane_offset;
    } t_pbv_in;

    typedef struct packed {
        logic signed [DIST_W-1:0] origin_x;
        logic signed [DIST_W-1:0] origin_y;
        logic signed [DIST_W-1:0] origin_z;
        logic signed [VEC_W-1:0]  up_x;
        logic signed [VEC_W-1:0]  up_y;
        logic signed [VEC_W-1:0]  up_z;
        logic signed [VEC_W-1:0]  right_x;
        logic signed [VEC_W-1:0]  right_y;
        logic signed [VEC_W-1:0]  right_z;
    } t_pbv_out;

endpackage

// ===== rtl/pbv_norm3.sv =====
// Pipelined 3-vector normalizer: squares, sum, bit-per-stage root, bit-per-stage divide.
module pbv_norm3 import pbv_pkg::*; #(
    parameter int FRAC   = VECTOR_FRAC_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic signed [WIDE_W-1:0] i_w [3],
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_vld,
    output logic signed [VEC_W-1:0]  o_v [3],
    output logic [SIDE_W-1:0]        o_side
);

    localparam logic [QUO_BITS-1:0] POS_MAX = QUO_BITS'(32767);
    localparam logic [QUO_BITS-1:0] NEG_MAX = QUO_BITS'(32768);

    // stage 1: magnitudes and squares
    logic              r_s1_vld;
    logic              r_s1_neg [3];
    logic [MAG_W-1:0]  r_s1_mag [3];
    logic [SUM_W-1:0]  r_s1_sq  [3];
    logic [SIDE_W-1:0] r_s1_side;
    logic [MAG_W-1:0]  n_mag    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_w[i][WIDE_W-1] ? MAG_W'(-i_w[i]) : MAG_W'(i_w[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_vld <= 1'b0;
        else          r_s1_vld <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s1_neg[i] <= i_w[i][WIDE_W-1];
            r_s1_mag[i] <= n_mag[i];
            r_s1_sq[i]  <= SUM_W'(n_mag[i]) * SUM_W'(n_mag[i]);
        end
        r_s1_side <= i_side;
    end

    // root pipeline, entry 0 holds the sum
    logic              r_rt_vld  [ROOT_STG+1];
    logic [SUM_W-1:0]  r_rt_s    [ROOT_STG+1];
    logic [SUM_W-1:0]  r_rt_r    [ROOT_STG+1];
    logic              r_rt_neg  [ROOT_STG+1][3];
    logic [MAG_W-1:0]  r_rt_mag  [ROOT_STG+1][3];
    logic [SIDE_W-1:0] r_rt_side [ROOT_STG+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rt_vld[0] <= 1'b0;
        else          r_rt_vld[0] <= r_s1_vld;
    end

    always_ff @(posedge i_clk) begin
        r_rt_s[0]    <= r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];
        r_rt_r[0]    <= '0;
        r_rt_neg[0]  <= r_s1_neg;
        r_rt_mag[0]  <= r_s1_mag;
        r_rt_side[0] <= r_s1_side;
    end

    for (genvar k = 0; k < ROOT_STG; k++) begin : g_root
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_STG - 1 - k));
        logic [SUM_W-1:0] n_t;
        logic [SUM_W-1:0] n_s;
        logic [SUM_W-1:0] n_r;

        always_comb begin
            n_t = r_rt_r[k] + BIT;
            if (r_rt_s[k] >= n_t) begin
                n_s = r_rt_s[k] - n_t;
                n_r = (r_rt_r[k] >> 1) + BIT;
            end else begin
                n_s = r_rt_s[k];
                n_r = r_rt_r[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_rt_vld[k+1] <= 1'b0;
            else          r_rt_vld[k+1] <= r_rt_vld[k];
        end

        always_ff @(posedge i_clk) begin
            r_rt_s[k+1]    <= n_s;
            r_rt_r[k+1]    <= n_r;
            r_rt_neg[k+1]  <= r_rt_neg[k];
            r_rt_mag[k+1]  <= r_rt_mag[k];
            r_rt_side[k+1] <= r_rt_side[k];
        end
    end

    // divide setup: numerator with half-length bias, overflow and zero-length flags
    logic [MAG_W-1:0]    n_len;
    logic [SUM_W-1:0]    n_num [3];
    logic [SUM_W-1:0]    n_lim;

    logic                r_dv_vld  [QUO_BITS+1];
    logic [SUM_W-1:0]    r_dv_rem  [QUO_BITS+1][3];
    logic [QUO_BITS-1:0] r_dv_q    [QUO_BITS+1][3];
    logic                r_dv_ovf  [QUO_BITS+1][3];
    logic                r_dv_neg  [QUO_BITS+1][3];
    logic                r_dv_zero [QUO_BITS+1];
    logic [MAG_W-1:0]    r_dv_len  [QUO_BITS+1];
    logic [SIDE_W-1:0]   r_dv_side [QUO_BITS+1];

    always_comb begin
        n_len = r_rt_r[ROOT_STG][MAG_W-1:0];
        n_lim = SUM_W'(n_len) << QUO_BITS;
        for (int i = 0; i < 3; i++) begin
            n_num[i] = (SUM_W'(r_rt_mag[ROOT_STG][i]) << FRAC) + SUM_W'(n_len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv_vld[0] <= 1'b0;
        else          r_dv_vld[0] <= r_rt_vld[ROOT_STG];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dv_rem[0][i] <= n_num[i];
            r_dv_q[0][i]   <= '0;
            r_dv_ovf[0][i] <= n_num[i] >= n_lim;
            r_dv_neg[0][i] <= r_rt_neg[ROOT_STG][i];
        end
        r_dv_zero[0] <= n_len == '0;
        r_dv_len[0]  <= n_len;
        r_dv_side[0] <= r_rt_side[ROOT_STG];
    end

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
        localparam int SH = QUO_BITS - 1 - k;
        logic [SUM_W-1:0]    n_dvs;
        logic [SUM_W-1:0]    n_rem [3];
        logic [QUO_BITS-1:0] n_q   [3];

        always_comb begin
            n_dvs = SUM_W'(r_dv_len[k]) << SH;
            for (int i = 0; i < 3; i++) begin
                n_rem[i] = r_dv_rem[k][i];
                n_q[i]   = r_dv_q[k][i];
                if (r_dv_rem[k][i] >= n_dvs) begin
                    n_rem[i]  = r_dv_rem[k][i] - n_dvs;
                    n_q[i][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_vld[k+1] <= 1'b0;
            else          r_dv_vld[k+1] <= r_dv_vld[k];
        end

        always_ff @(posedge i_clk) begin
            r_dv_rem[k+1]  <= n_rem;
            r_dv_q[k+1]    <= n_q;
            r_dv_ovf[k+1]  <= r_dv_ovf[k];
            r_dv_neg[k+1]  <= r_dv_neg[k];
            r_dv_zero[k+1] <= r_dv_zero[k];
            r_dv_len[k+1]  <= r_dv_len[k];
            r_dv_side[k+1] <= r_dv_side[k];
        end
    end

    // sign, saturation, zero length
    logic                    r_o_vld;
    logic signed [VEC_W-1:0] r_o_v [3];
    logic [SIDE_W-1:0]       r_o_side;
    logic signed [VEC_W-1:0] n_v   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_zero[QUO_BITS]) begin
                n_v[i] = '0;
            end else if (!r_dv_neg[QUO_BITS][i]) begin
                if (r_dv_ovf[QUO_BITS][i] || r_dv_q[QUO_BITS][i] > POS_MAX)
                    n_v[i] = VEC_W'(32767);
                else
                    n_v[i] = VEC_W'(r_dv_q[QUO_BITS][i]);
            end else begin
                if (r_dv_ovf[QUO_BITS][i] || r_dv_q[QUO_BITS][i] > NEG_MAX)
                    n_v[i] = VEC_W'(-32768);
                else
                    n_v[i] = VEC_W'(-r_dv_q[QUO_BITS][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else          r_o_vld <= r_dv_vld[QUO_BITS];
    end

    always_ff @(posedge i_clk) begin
        r_o_v    <= n_v;
        r_o_side <= r_dv_side[QUO_BITS];
    end

    assign o_vld  = r_o_vld;
    assign o_v    = r_o_v;
    assign o_side = r_o_side;

endmodule

// ===== rtl/plane_basis_vectors.sv =====
// Plane tangent basis: up, right and origin vectors from a plane normal and offset.
// Throughput: one plane per cycle; busy is never raised, as every stage advances each cycle.
// Most of the pipeline lies in the two normalizers (32-stage root, 17-stage divide each).
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
// The receiver cannot stall: each result shows for exactly one cycle with o_strobe.
module plane_basis_vectors import pbv_pkg::*; #(
    parameter int VECTOR_FRAC_BITS = VECTOR_FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_pbv_in  i_plane,
    output logic     o_busy,
    output logic     o_strobe,
    output t_pbv_out o_result
);

    localparam int F      = VECTOR_FRAC_BITS;
    localparam int PROD_W = 2 * VEC_W;
    localparam int ORG_W  = DIST_W + VEC_W;
    localparam int SIDE_W = 3 * VEC_W + 3 * DIST_W;

    localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (F - 1);
    localparam logic [ORG_W-1:0]  HALF_O = ORG_W'(1) << (F - 1);
    localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(1) << F;
    localparam logic [ORG_W-1:0]  ORG_POS = ORG_W'(33'h0_7FFF_FFFF);
    localparam logic [ORG_W-1:0]  ORG_NEG = ORG_W'(33'h0_8000_0000);

    // stage A: input capture
    logic                     r_a_vld;
    logic signed [VEC_W-1:0]  r_a_n [3];
    logic signed [DIST_W-1:0] r_a_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else          r_a_vld <= i_start;
    end

    always_ff @(posedge i_clk) begin
        r_a_n[0] <= i_plane.normal_x;
        r_a_n[1] <= i_plane.normal_y;
        r_a_n[2] <= i_plane.normal_z;
        r_a_d    <= i_plane.plane_offset;
    end

    // stage B: major axis, seed, projection and origin products
    logic [VEC_W:0]           n_abs [3];
    logic [VEC_W:0]           n_best;
    logic [1:0]               n_seed;
    logic signed [VEC_W-1:0]  n_v;

    logic                     r_b_vld;
    logic [1:0]               r_b_seed;
    logic signed [PROD_W-1:0] r_b_p  [3];
    logic signed [ORG_W-1:0]  r_b_od [3];
    logic signed [VEC_W-1:0]  r_b_n  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_abs[i] = r_a_n[i][VEC_W-1] ? (VEC_W+1)'(-r_a_n[i]) : (VEC_W+1)'(r_a_n[i]);
        end
        // lowest index wins a tie
        n_best = n_abs[0];
        n_seed = 2'd2;
        if (n_abs[1] > n_best) n_best = n_abs[1];
        if (n_abs[2] > n_best) n_seed = 2'd0;
        n_v = (n_seed == 2'd0) ? r_a_n[0] : r_a_n[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else          r_b_vld <= r_a_vld;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_b_p[i]  <= PROD_W'(n_v) * PROD_W'(r_a_n[i]);
            r_b_od[i] <= ORG_W'(r_a_d) * ORG_W'(r_a_n[i]);
        end
        r_b_seed <= n_seed;
        r_b_n    <= r_a_n;
    end

    // stage C: round to nearest (ties away), unnormalized up, saturated origin
    logic [PROD_W-1:0]        n_pm [3];
    logic [PROD_W-1:0]        n_pq [3];
    logic signed [WIDE_W-1:0] n_u  [3];
    logic [ORG_W-1:0]         n_om [3];
    logic [ORG_W-1:0]         n_oq [3];
    logic signed [DIST_W-1:0] n_org [3];

    logic                     r_c_vld;
    logic signed [WIDE_W-1:0] r_c_u   [3];
    logic signed [DIST_W-1:0] r_c_org [3];
    logic signed [VEC_W-1:0]  r_c_n   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pm[i] = r_b_p[i][PROD_W-1] ? PROD_W'(-r_b_p[i]) : PROD_W'(r_b_p[i]);
            n_pq[i] = (n_pm[i] + HALF_P) >> F;
            n_u[i]  = ((r_b_seed == 2'(i)) ? ONE : WIDE_W'(0))
                    - (r_b_p[i][PROD_W-1] ? -WIDE_W'(n_pq[i]) : WIDE_W'(n_pq[i]));

            n_om[i] = r_b_od[i][ORG_W-1] ? ORG_W'(-r_b_od[i]) : ORG_W'(r_b_od[i]);
            n_oq[i] = (n_om[i] + HALF_O) >> F;
            if (!r_b_od[i][ORG_W-1]) begin
                n_org[i] = (n_oq[i] > ORG_POS) ? DIST_W'(32'h7FFF_FFFF) : DIST_W'(n_oq[i]);
            end else begin
                n_org[i] = (n_oq[i] > ORG_NEG) ? DIST_W'(32'h8000_0000) : DIST_W'(-n_oq[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_vld <= 1'b0;
        else          r_c_vld <= r_b_vld;
    end

    always_ff @(posedge i_clk) begin
        r_c_u   <= n_u;
        r_c_org <= n_org;
        r_c_n   <= r_b_n;
    end

    // first normalizer: up; normal and origin ride along
    logic                    w_up_vld;
    logic signed [VEC_W-1:0] w_up [3];
    logic [SIDE_W-1:0]       w_side1;
    logic signed [VEC_W-1:0]  w_n1   [3];
    logic signed [DIST_W-1:0] w_org1 [3];

    pbv_norm3 #(
        .FRAC   (F),
        .SIDE_W (SIDE_W)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .i_w     (r_c_u),
        .i_side  ({r_c_n[0], r_c_n[1], r_c_n[2], r_c_org[0], r_c_org[1], r_c_org[2]}),
        .o_vld   (w_up_vld),
        .o_v     (w_up),
        .o_side  (w_side1)
    );

    assign {w_n1[0], w_n1[1], w_n1[2], w_org1[0], w_org1[1], w_org1[2]} = w_side1;

    // stage D: cross product terms of up x n
    logic                     r_d_vld;
    logic signed [PROD_W-1:0] r_d_pp  [6];
    logic signed [VEC_W-1:0]  r_d_up  [3];
    logic signed [DIST_W-1:0] r_d_org [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_vld <= 1'b0;
        else          r_d_vld <= w_up_vld;
    end

    always_ff @(posedge i_clk) begin
        r_d_pp[0] <= PROD_W'(w_up[1]) * PROD_W'(w_n1[2]);
        r_d_pp[1] <= PROD_W'(w_up[2]) * PROD_W'(w_n1[1]);
        r_d_pp[2] <= PROD_W'(w_up[2]) * PROD_W'(w_n1[0]);
        r_d_pp[3] <= PROD_W'(w_up[0]) * PROD_W'(w_n1[2]);
        r_d_pp[4] <= PROD_W'(w_up[0]) * PROD_W'(w_n1[1]);
        r_d_pp[5] <= PROD_W'(w_up[1]) * PROD_W'(w_n1[0]);
        r_d_up    <= w_up;
        r_d_org   <= w_org1;
    end

    // stage E: exact cross product with 2F fraction bits
    logic                     r_e_vld;
    logic signed [WIDE_W-1:0] r_e_cr  [3];
    logic signed [VEC_W-1:0]  r_e_up  [3];
    logic signed [DIST_W-1:0] r_e_org [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_vld <= 1'b0;
        else          r_e_vld <= r_d_vld;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e_cr[i] <= WIDE_W'(r_d_pp[2*i]) - WIDE_W'(r_d_pp[2*i+1]);
        end
        r_e_up  <= r_d_up;
        r_e_org <= r_d_org;
    end

    // second normalizer: right; up and origin ride along
    logic                     w_rt_vld;
    logic signed [VEC_W-1:0]  w_rt [3];
    logic [SIDE_W-1:0]        w_side2;
    logic signed [VEC_W-1:0]  w_up2  [3];
    logic signed [DIST_W-1:0] w_org2 [3];

    pbv_norm3 #(
        .FRAC   (F),
        .SIDE_W (SIDE_W)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_e_vld),
        .i_w     (r_e_cr),
        .i_side  ({r_e_up[0], r_e_up[1], r_e_up[2], r_e_org[0], r_e_org[1], r_e_org[2]}),
        .o_vld   (w_rt_vld),
        .o_v     (w_rt),
        .o_side  (w_side2)
    );

    assign {w_up2[0], w_up2[1], w_up2[2], w_org2[0], w_org2[1], w_org2[2]} = w_side2;

    // result beat register
    logic     r_out_vld;
    t_pbv_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else          r_out_vld <= w_rt_vld;
    end

    always_ff @(posedge i_clk) begin
        r_out.origin_x <= w_org2[0];
        r_out.origin_y <= w_org2[1];
        r_out.origin_z <= w_org2[2];
        r_out.up_x     <= w_up2[0];
        r_out.up_y     <= w_up2[1];
        r_out.up_z     <= w_up2[2];
        r_out.right_x  <= w_rt[0];
        r_out.right_y  <= w_rt[1];
        r_out.right_z  <= w_rt[2];
    end

    assign o_busy   = 1'b0;
    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule
